FILE: hw/rtl/ufsc_pkg.sv
// ufsc_pkg: shared types and constants for the frame sync and checksum block.
// Holds the header pattern, the command item between front and back, and the result item.
// Depends on nothing.
package ufsc_pkg;

   localparam logic [7:0]  HDR_B0     = 8'h23;   // '#'
   localparam logic [7:0]  HDR_B1     = 8'h73;   // 's'
   localparam logic [7:0]  HDR_B2     = 8'h74;   // 't'
   localparam logic [7:0]  HDR_B3     = 8'h61;   // 'a'
   localparam logic [23:0] HDR_FIRST3 = {HDR_B0, HDR_B1, HDR_B2};
   localparam logic [7:0]  HDR_SUM    = 8'(HDR_B0 + HDR_B1 + HDR_B2 + HDR_B3);
   localparam logic [6:0]  HDR_LEN    = 7'd4;

   typedef enum logic {
      CMD_HEADER,
      CMD_DATA
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic [6:0]   byte_index;
      logic         last_of_frame;
      logic         checksum_ok;
   } cmd_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [6:0] byte_index;
      logic       last_of_frame;
      logic       checksum_ok;
   } rsp_type;

   function automatic logic [7:0] hdr_byte(input logic [1:0] sel);
      logic [7:0] b;
      case (sel)
         2'd0: b = HDR_B0;
         2'd1: b = HDR_B1;
         2'd2: b = HDR_B2;
         2'd3: b = HDR_B3;
         default: b = HDR_B0;
      endcase
      return b;
   endfunction

endpackage

FILE: hw/rtl/uart_frame_sync_checksum_top.sv
// uart_frame_sync_checksum_top: header sync and additive checksum check on a byte stream.
// Instantiates ufsc_front, ufsc_cmd_fifo and ufsc_back; depends on ufsc_pkg.
//
//   channel  | ports                              | accepted when
//   ---------+------------------------------------+---------------------------
//   request  | req_push, req_full, req_rx_byte    | req_push && !req_full
//   response | rsp_empty, rsp_pop, rsp_data_byte, | rsp_pop && !rsp_empty
//            | rsp_byte_index, rsp_last_of_frame, |
//            | rsp_checksum_ok                    |
//
// One byte is taken per cycle while req_full is low; the front classifies it in that
// same cycle. A completed header emits four items from the back end, every other
// frame byte one item; the result register delivers at most one item per cycle.
// The command queue (CMD_DEPTH entries) absorbs the header burst; req_full rises
// only when it fills because the response side stalls.
// Reset is synchronous, active high, and returns the block to hunting.
module uart_frame_sync_checksum_top #(
   parameter int FRAME_LEN = 100,
   parameter int CMD_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_data_byte,
   output logic [6:0] rsp_byte_index,
   output logic       rsp_last_of_frame,
   output logic       rsp_checksum_ok
);

   logic              req_accept;
   logic              cmd_push;
   ufsc_pkg::cmd_type cmd_in_q;
   logic              head_valid;
   ufsc_pkg::cmd_type head_cmd;
   logic              head_pop;
   ufsc_pkg::rsp_type rsp;

   // take a byte whenever the command queue has room
   assign req_accept = req_push && !req_full;

   ufsc_front #(
      .FRAME_LEN(FRAME_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .rx_byte  (req_rx_byte),
      .cmd_push (cmd_push),
      .cmd      (cmd_in_q)
   );

   ufsc_cmd_fifo #(
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd_in_q),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ufsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (head_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   // drive the result fields straight from the output register
   assign rsp_data_byte     = rsp.data_byte;
   assign rsp_byte_index    = rsp.byte_index;
   assign rsp_last_of_frame = rsp.last_of_frame;
   assign rsp_checksum_ok   = rsp.checksum_ok;

endmodule

FILE: hw/rtl/ufsc_front.sv
// ufsc_front: header hunt and frame tracking, one received byte per cycle while accept is high.
// Emits one command per header or frame byte into the command queue.
// Depends on ufsc_pkg.
module ufsc_front #(
   parameter int FRAME_LEN = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   output logic              cmd_push,
   output ufsc_pkg::cmd_type cmd
);

   localparam logic [6:0] LAST_POS = 7'(FRAME_LEN - 1);

   logic [23:0] window_ff, window_in;
   logic        in_frame_ff, in_frame_in;
   logic [6:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;

   always_comb begin
      window_in   = window_ff;
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      cmd_push    = 1'b0;
      cmd.kind          = ufsc_pkg::CMD_DATA;
      cmd.data_byte     = rx_byte;
      cmd.byte_index    = pos_ff;
      cmd.last_of_frame = 1'b0;
      cmd.checksum_ok   = 1'b0;
      if (accept) begin
         if (!in_frame_ff) begin
            if (window_ff == ufsc_pkg::HDR_FIRST3 && rx_byte == ufsc_pkg::HDR_B3) begin
               // header complete: back end expands it into four items
               cmd_push       = 1'b1;
               cmd.kind       = ufsc_pkg::CMD_HEADER;
               cmd.byte_index = 7'd0;
               in_frame_in    = 1'b1;
               pos_in         = ufsc_pkg::HDR_LEN;
               sum_in         = ufsc_pkg::HDR_SUM;
               window_in      = 24'd0;
            end else begin
               window_in = {window_ff[15:0], rx_byte};
            end
         end else if (pos_ff >= LAST_POS) begin
            cmd_push          = 1'b1;
            cmd.last_of_frame = 1'b1;
            cmd.checksum_ok   = (rx_byte == sum_ff);
            in_frame_in       = 1'b0;
            pos_in            = 7'd0;
            sum_in            = 8'd0;
            window_in         = 24'd0;
         end else begin
            cmd_push = 1'b1;
            sum_in   = sum_ff + rx_byte;
            pos_in   = pos_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= 24'd0;
         in_frame_ff <= 1'b0;
         pos_ff      <= 7'd0;
         sum_ff      <= 8'd0;
      end else begin
         window_ff   <= window_in;
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
      end
   end

`ifndef SYNTHESIS
   a_window_clear_in_frame: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> window_ff == 24'd0)
      else $error("header window not clear inside a frame");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (pos_ff >= ufsc_pkg::HDR_LEN && pos_ff <= LAST_POS))
      else $error("frame position out of range");
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (pos_ff == 7'd0 && sum_ff == 8'd0))
      else $error("position or sum not clear while hunting");
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && cmd.last_of_frame) |-> cmd.byte_index == LAST_POS)
      else $error("checksum byte at wrong index");
`endif

endmodule

FILE: hw/rtl/ufsc_cmd_fifo.sv
// ufsc_cmd_fifo: short command queue between front and back ends.
// Register array with wrapping pointers and an occupancy count.
// Depends on ufsc_pkg.
module ufsc_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ufsc_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output ufsc_pkg::cmd_type head_cmd
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   ufsc_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("command queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full command queue");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == DEPTH_CNT) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

FILE: hw/rtl/ufsc_back.sv
// ufsc_back: expands commands into result items and holds the output register.
// A header command yields four items; a data command yields one.
// Depends on ufsc_pkg.
module ufsc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  ufsc_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ufsc_pkg::rsp_type rsp
);

   logic                 out_valid_ff, out_valid_in;
   ufsc_pkg::rsp_type    out_ff, out_in;
   logic [1:0]           beat_ff, beat_in;
   logic                 advance;

   assign advance   = cmd_valid && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      out_in       = out_ff;
      beat_in      = beat_ff;
      cmd_pop      = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (advance) begin
         out_valid_in = 1'b1;
         if (cmd.kind == ufsc_pkg::CMD_HEADER) begin
            out_in.data_byte     = ufsc_pkg::hdr_byte(beat_ff);
            out_in.byte_index    = {5'd0, beat_ff};
            out_in.last_of_frame = 1'b0;
            out_in.checksum_ok   = 1'b0;
            beat_in              = beat_ff + 2'd1;
            cmd_pop              = (beat_ff == 2'd3);
         end else begin
            out_in.data_byte     = cmd.data_byte;
            out_in.byte_index    = cmd.byte_index;
            out_in.last_of_frame = cmd.last_of_frame;
            out_in.checksum_ok   = cmd.checksum_ok;
            cmd_pop              = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         beat_ff      <= beat_in;
      end
   end

`ifndef SYNTHESIS
   a_beat_on_header: assert property (@(posedge clock) disable iff (reset)
      (beat_ff != 2'd0) |-> (cmd_valid && cmd.kind == ufsc_pkg::CMD_HEADER))
      else $error("header expansion interrupted");
   a_pop_needs_advance: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> advance)
      else $error("command popped without issuing an item");
   a_ok_only_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.checksum_ok) |-> out_ff.last_of_frame)
      else $error("checksum flag on a non-final byte");
`endif

endmodule

FILE: bench/ufsc_frame_checker.sv
`timescale 1ns / 100ps
// ufsc_frame_checker: watches both queues of the frame sync block, predicts and compares.
// Depends on ufsc_pkg for the header bytes and the result item type.
module ufsc_frame_checker #(
   parameter int FRAME_LEN = 100
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_data_byte,
   input  logic [6:0] rsp_byte_index,
   input  logic       rsp_last_of_frame,
   input  logic       rsp_checksum_ok,
   input  logic       end_of_test,
   output int         fail_count,
   output int         pending,
   output int         items_checked,
   output int         frames_good,
   output int         frames_bad
);

   localparam logic [31:0] HDR_WORD = {ufsc_pkg::HDR_B0, ufsc_pkg::HDR_B1,
                                       ufsc_pkg::HDR_B2, ufsc_pkg::HDR_B3};

   ufsc_pkg::rsp_type frame_items_due[$];
   logic [23:0]       hunt_window;
   logic              framing;
   logic [6:0]        next_index;
   logic [7:0]        frame_sum;
   bit                tail_checked;

   task automatic report_mismatch(input string what);
      $display("[%0t] frame check: %s", $time, what);
      fail_count++;
   endtask

   // Advance the predicted sync state by one received byte.
   task automatic track_rx_byte(input logic [7:0] b);
      ufsc_pkg::rsp_type r;
      if (!framing) begin
         if (hunt_window == ufsc_pkg::HDR_FIRST3 && b == ufsc_pkg::HDR_B3) begin
            for (int k = 0; k < 4; k++) begin
               r.data_byte     = HDR_WORD[31 - 8 * k -: 8];
               r.byte_index    = 7'(k);
               r.last_of_frame = 1'b0;
               r.checksum_ok   = 1'b0;
               frame_items_due.push_back(r);
            end
            frame_sum   = ufsc_pkg::HDR_SUM;
            next_index  = ufsc_pkg::HDR_LEN;
            framing     = 1'b1;
            hunt_window = '0;
         end else begin
            hunt_window = {hunt_window[15:0], b};
         end
      end else if (int'(next_index) >= FRAME_LEN - 1) begin
         r.data_byte     = b;
         r.byte_index    = next_index;
         r.last_of_frame = 1'b1;
         r.checksum_ok   = (b == frame_sum);
         frame_items_due.push_back(r);
         if (r.checksum_ok) frames_good++;
         else frames_bad++;
         framing     = 1'b0;
         next_index  = '0;
         frame_sum   = '0;
         hunt_window = '0;
      end else begin
         r.data_byte     = b;
         r.byte_index    = next_index;
         r.last_of_frame = 1'b0;
         r.checksum_ok   = 1'b0;
         frame_items_due.push_back(r);
         frame_sum  = frame_sum + b;
         next_index = next_index + 7'd1;
      end
   endtask

   always @(posedge clock) begin
      ufsc_pkg::rsp_type seen;
      ufsc_pkg::rsp_type want;
      if (reset) begin
         frame_items_due.delete();
         hunt_window   = '0;
         framing       = 1'b0;
         next_index    = '0;
         frame_sum     = '0;
         fail_count    = 0;
         items_checked = 0;
         frames_good   = 0;
         frames_bad    = 0;
         tail_checked  = 1'b0;
      end else begin
         if (req_push && !req_full) track_rx_byte(req_rx_byte);
         if (rsp_pop && !rsp_empty) begin
            seen = {rsp_data_byte, rsp_byte_index, rsp_last_of_frame, rsp_checksum_ok};
            items_checked++;
            if (frame_items_due.size() == 0) begin
               report_mismatch($sformatf(
                  "item with nothing due: byte %02h index %0d last %b ok %b",
                  seen.data_byte, seen.byte_index, seen.last_of_frame, seen.checksum_ok));
            end else begin
               want = frame_items_due.pop_front();
               if (seen !== want)
                  report_mismatch($sformatf("got %02h/%0d/%b/%b, want %02h/%0d/%b/%b",
                     seen.data_byte, seen.byte_index, seen.last_of_frame, seen.checksum_ok,
                     want.data_byte, want.byte_index, want.last_of_frame, want.checksum_ok));
            end
         end
         if (end_of_test && !tail_checked) begin
            tail_checked = 1'b1;
            if (frame_items_due.size() != 0)
               report_mismatch($sformatf("%0d items never arrived", frame_items_due.size()));
         end
      end
      pending <= frame_items_due.size();
   end

endmodule

FILE: bench/tb_uart_frame_sync_checksum_top.sv
`timescale 1ns / 100ps
// tb_uart_frame_sync_checksum_top: byte stimulus, output draining and verdict.
// Depends on ufsc_pkg, uart_frame_sync_checksum_top and ufsc_frame_checker.
module tb_uart_frame_sync_checksum_top;

   localparam int          FRAME_LEN = 100;
   localparam logic [31:0] HDR_WORD  = {ufsc_pkg::HDR_B0, ufsc_pkg::HDR_B1,
                                        ufsc_pkg::HDR_B2, ufsc_pkg::HDR_B3};

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_rx_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_data_byte;
   logic [6:0] rsp_byte_index;
   logic       rsp_last_of_frame;
   logic       rsp_checksum_ok;
   logic       end_of_test;

   int fail_count;
   int pending;
   int items_checked;
   int frames_good;
   int frames_bad;

   // Sender-side bookkeeping: what the byte stream looks like from here.
   int         bytes_sent;
   int         next_gap;
   bit         send_idle;
   logic [7:0] gen_sum;
   int         gen_pos;

   uart_frame_sync_checksum_top #(
      .FRAME_LEN(FRAME_LEN)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_of_frame(rsp_last_of_frame),
      .rsp_checksum_ok  (rsp_checksum_ok)
   );

   ufsc_frame_checker #(
      .FRAME_LEN(FRAME_LEN)
   ) frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_of_frame(rsp_last_of_frame),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .end_of_test      (end_of_test),
      .fail_count       (fail_count),
      .pending          (pending),
      .items_checked    (items_checked),
      .frames_good      (frames_good),
      .frames_bad       (frames_bad)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs; the slowest legal run is far shorter.
   initial begin
      #200000;
      $display("timeout: output queue never drained");
      $display("TB_ERROR");
      $finish;
   end

   // Offer one byte; hold it until the input queue takes it. The gap before the
   // next byte is drawn here so that push drops only when a gap really follows,
   // which keeps push to a single assignment per edge.
   task automatic push_byte(input logic [7:0] b);
      repeat (next_gap) @(posedge clock);
      req_push    <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
      next_gap = send_idle ? $urandom_range(14) : 0;
      if (next_gap != 0) req_push <= 1'b0;
   endtask

   // Drop push right after the last accepted byte of a burst.
   task automatic stop_push();
      if (next_gap == 0) req_push <= 1'b0;
   endtask

   // Send a byte inside a frame and keep the running sum the frame will need.
   task automatic send_in_frame(input logic [7:0] b);
      push_byte(b);
      gen_sum = gen_sum + b;
      gen_pos++;
   endtask

   task automatic send_header();
      for (int k = 0; k < 4; k++) push_byte(HDR_WORD[31 - 8 * k -: 8]);
      gen_sum = ufsc_pkg::HDR_SUM;
      gen_pos = 4;
   endtask

   // Fill the current frame with random bytes up to the checksum position, now
   // and then dropping a full header in as plain data, then close it with a
   // matching or corrupted sum. With tail_hdr the last three data bytes spell
   // the start of a header, which must not carry over past the frame end.
   task automatic finish_frame(input bit sum_good, input bit tail_hdr);
      logic [7:0] b;
      while (gen_pos < FRAME_LEN - 1) begin
         if (tail_hdr && gen_pos >= FRAME_LEN - 4) begin
            send_in_frame(HDR_WORD[31 - 8 * (gen_pos - (FRAME_LEN - 4)) -: 8]);
         end else if (gen_pos <= FRAME_LEN - 8 && $urandom_range(15) == 0) begin
            for (int k = 0; k < 4; k++) send_in_frame(HDR_WORD[31 - 8 * k -: 8]);
         end else begin
            b = 8'($urandom_range(255));
            send_in_frame(b);
         end
      end
      if (sum_good) push_byte(gen_sum);
      else push_byte(gen_sum ^ 8'($urandom_range(1, 255)));
      gen_pos = 0;
   endtask

   // Hunting-phase filler: random bytes and headers broken off before their
   // last byte. Stray 'a' bytes are flipped so noise never completes a header.
   task automatic send_noise(input int count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            push_byte(ufsc_pkg::HDR_B0);
            push_byte(ufsc_pkg::HDR_B1);
            if ($urandom_range(1) == 1) push_byte(ufsc_pkg::HDR_B2);
         end else begin
            b = 8'($urandom_range(255));
            if (b == ufsc_pkg::HDR_B3) b = ~b;
            push_byte(b);
         end
      end
   endtask

   // Output side: pop with random waits, switching now and then between an idle
   // and a greedy mode. After the 20th item, hold off for a long stretch so the
   // internal queue fills and the input side has to stall.
   initial begin : drain_side
      int  taken;
      int  wait_left;
      int  hold_left;
      bit  idle_on;
      taken     = 0;
      wait_left = 0;
      hold_left = 0;
      idle_on   = 1'b1;
      rsp_pop   = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            taken++;
            if (taken == 20) hold_left = 80;
            if ($urandom_range(7) == 0) idle_on = !idle_on;
            wait_left = idle_on ? $urandom_range(14) : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin : byte_source
      int random_frames;
      reset        = 1'b1;
      req_push     = 1'b0;
      req_rx_byte  = 8'h00;
      end_of_test  = 1'b0;
      bytes_sent   = 0;
      next_gap     = 0;
      send_idle    = 1'b1;
      gen_sum      = '0;
      gen_pos      = 0;
      random_frames = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme bytes while hunting, a header broken before its last
      // byte, then a header found through an overlap ("##sta").
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(ufsc_pkg::HDR_B0);
      push_byte(ufsc_pkg::HDR_B1);
      push_byte(ufsc_pkg::HDR_B2);
      push_byte(8'h55);
      push_byte(ufsc_pkg::HDR_B0);
      send_header();
      // Inside the frame: extremes, a complete header passed on as data, and
      // the bytes around the sign bit.
      send_in_frame(8'h00);
      send_in_frame(8'hFF);
      for (int k = 0; k < 4; k++) send_in_frame(HDR_WORD[31 - 8 * k -: 8]);
      send_in_frame(8'h80);
      send_in_frame(8'h7F);

      // Finish this frame with no idling so the long output stall backs the
      // block up; end it on a good sum with a header start just before it,
      // then send the closing 'a', which must not complete anything.
      send_idle = 1'b0;
      finish_frame(1'b1, 1'b1);
      push_byte(ufsc_pkg::HDR_B3);
      stop_push();

      // Pause until every item due so far has come out.
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // Random part: well-formed frames with random content and noise between,
      // alternating bad and good sums, idling mode drawn per frame.
      while (bytes_sent < 170) begin
         send_idle = ($urandom_range(3) != 0);
         send_noise($urandom_range(0, 8));
         send_header();
         finish_frame(random_frames % 2 == 1, 1'b0);
         random_frames++;
      end
      send_noise(6);
      stop_push();

      // Drain, then leave a few idle cycles for any stray item to show up.
      @(posedge clock);
      for (int i = 0; i < 20000 && pending != 0; i++) @(posedge clock);
      repeat (20) @(posedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Run: %0d bytes sent, %0d items checked, %0d frames with a matching sum, %0d bad.",
         bytes_sent, items_checked, frames_good, frames_bad);
      $display("Also hit: broken and overlapped headers, header bytes as data, full input stall.");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
